>>> hdl/swsbm_pkg.sv
// Package with the shared types, codes and reset values of the servo bus master.
`timescale 1ns / 1ps
`default_nettype none

package swsbm_pkg;

    // Frame buffer depth default.
    localparam int FRAME_MAX_DEF = 8;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [15:0] BIT_TICKS_RST     = 16'd104;
    localparam logic [23:0] REPLY_TIMEOUT_RST = 24'd50000;
    localparam logic [15:0] GAP_TICKS_RST     = 16'd100;
    localparam logic [23:0] ZERO_SETTLE_RST   = 24'd5000;

    localparam logic [7:0]  SYNC_BYTE       = 8'hAA;
    localparam logic [3:0]  FRAME_LEN_MOVE  = 4'd8;
    localparam logic [3:0]  FRAME_LEN_SHORT = 4'd2;
    localparam logic [3:0]  UART_BITS       = 4'd10;
    localparam logic [3:0]  DATA_BITS       = 4'd8;
    localparam logic [3:0]  REPLY_BYTES     = 4'd4;
    localparam logic [31:0] POS_TIMEOUT     = 32'h8000_0000;

    typedef enum logic [2:0] {
        CMD_MOVE      = 3'd0,
        CMD_MOVE_WAIT = 3'd1,
        CMD_POSITION  = 3'd2,
        CMD_HALT      = 3'd3,
        CMD_QUERY     = 3'd4,
        CMD_ZERO      = 3'd5,
        CMD_HOLD_OFF  = 3'd6,
        CMD_HOLD_ON   = 3'd7
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_TICKS     = 2'd0,
        CFG_REPLY_TIMEOUT = 2'd1,
        CFG_GAP_TICKS     = 2'd2,
        CFG_ZERO_SETTLE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TX,
        PH_LINE_LOW,
        PH_LINE_HIGH,
        PH_RX_WAIT,
        PH_RX_BITS,
        PH_GAP
    } t_phase;

    typedef struct packed {
        logic [15:0] bit_ticks;
        logic [23:0] reply_timeout_ticks;
        logic [15:0] gap_ticks;
        logic [23:0] zero_settle_ticks;
    } t_cfg;

    typedef struct packed {
        logic               operation;
        logic [2:0]         command;
        logic signed [31:0] target_angle;
        logic [7:0]         move_speed;
        logic               line_level;
    } t_in_word;

    typedef struct packed {
        logic               pull_low;
        logic               busy_res;
        logic               done_res;
        logic signed [31:0] position;
        logic               moving;
        logic               timed_out;
    } t_out_word;

endpackage

`default_nettype wire

>>> hdl/swsbm_in_if.sv
// Command and tick channel of the servo bus master.
`timescale 1ns / 1ps
`default_nettype none

interface swsbm_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [2:0]         command;
    logic signed [31:0] target_angle;
    logic [7:0]         move_speed;
    logic               line_level;

    modport source (
        output valid, operation, command, target_angle, move_speed, line_level,
        input  ready
    );
    modport sink (
        input  valid, operation, command, target_angle, move_speed, line_level,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/swsbm_out_if.sv
// Result channel of the servo bus master.
`timescale 1ns / 1ps
`default_nettype none

interface swsbm_out_if;
    logic               valid;
    logic               ready;
    logic               pull_low;
    logic               busy_res;
    logic               done_res;
    logic signed [31:0] position;
    logic               moving;
    logic               timed_out;

    modport source (
        output valid, pull_low, busy_res, done_res, position, moving, timed_out,
        input  ready
    );
    modport sink (
        input  valid, pull_low, busy_res, done_res, position, moving, timed_out,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/swsbm_core.sv
// Bus sequencer: frame builder, bit timing, reply sampling and the state it keeps.
`timescale 1ns / 1ps
`default_nettype none

module swsbm_core #(
    parameter int FRAME_MAX = swsbm_pkg::FRAME_MAX_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  swsbm_pkg::t_in_word   i_word,
    input  swsbm_pkg::t_cfg       i_cfg,
    output swsbm_pkg::t_out_word  o_result
);

    localparam int IDX_W = $clog2(FRAME_MAX);

    swsbm_pkg::t_phase r_phase, n_phase;
    swsbm_pkg::t_cmd   r_pending, n_pending;
    logic [7:0]  r_frame [FRAME_MAX];
    logic [3:0]  r_frame_length, n_frame_length;
    logic [3:0]  r_byte_index, n_byte_index;
    logic [3:0]  r_bit_index, n_bit_index;
    logic [16:0] r_bit_timer, n_bit_timer;
    logic [23:0] r_wait_timer, n_wait_timer;
    logic [31:0] r_reply_shift, n_reply_shift;
    logic [31:0] r_last_position, n_last_position;
    logic        r_last_moving, n_last_moving;
    logic        r_timeout_flag, n_timeout_flag;

    logic        done;
    logic        start_en;
    logic        gap_go;
    logic [23:0] gap_len;
    logic [15:0] bt;
    logic [14:0] half_bt;
    logic [23:0] timeout_lim;
    logic [23:0] wait_inc;
    swsbm_pkg::t_cmd cmd_eff;
    logic [7:0]  checksum;
    logic [7:0]  tx_byte;
    logic [2:0]  tx_bit_sel;
    logic        pull;

    // A zero register value behaves as one for the bit time and the timeout.
    assign bt          = (i_cfg.bit_ticks == 16'd0) ? 16'd1 : i_cfg.bit_ticks;
    assign half_bt     = bt[15:1];
    assign timeout_lim = (i_cfg.reply_timeout_ticks == 24'd0) ? 24'd1
                                                              : i_cfg.reply_timeout_ticks;
    assign wait_inc    = r_wait_timer + 24'd1;

    // A move with speed zero is sent as a stop.
    always_comb begin
        cmd_eff = swsbm_pkg::t_cmd'(i_word.command);
        if ((cmd_eff == swsbm_pkg::CMD_MOVE || cmd_eff == swsbm_pkg::CMD_MOVE_WAIT)
                && i_word.move_speed == 8'd0) begin
            cmd_eff = swsbm_pkg::CMD_HALT;
        end
    end

    assign checksum = ~(8'({5'd0, cmd_eff}) + i_word.target_angle[31:24]
                      + i_word.target_angle[23:16] + i_word.target_angle[15:8]
                      + i_word.target_angle[7:0] + i_word.move_speed);

    always_comb begin
        n_phase         = r_phase;
        n_pending       = r_pending;
        n_frame_length  = r_frame_length;
        n_byte_index    = r_byte_index;
        n_bit_index     = r_bit_index;
        n_bit_timer     = r_bit_timer;
        n_wait_timer    = r_wait_timer;
        n_reply_shift   = r_reply_shift;
        n_last_position = r_last_position;
        n_last_moving   = r_last_moving;
        n_timeout_flag  = r_timeout_flag;
        done            = 1'b0;
        start_en        = 1'b0;
        gap_go          = 1'b0;
        gap_len         = 24'd0;

        if (i_step && i_word.operation) begin
            if (r_phase == swsbm_pkg::PH_IDLE) begin
                start_en       = 1'b1;
                n_pending      = cmd_eff;
                n_frame_length = (cmd_eff == swsbm_pkg::CMD_MOVE
                                  || cmd_eff == swsbm_pkg::CMD_MOVE_WAIT)
                                 ? swsbm_pkg::FRAME_LEN_MOVE : swsbm_pkg::FRAME_LEN_SHORT;
                if (cmd_eff == swsbm_pkg::CMD_POSITION || cmd_eff == swsbm_pkg::CMD_QUERY) begin
                    n_timeout_flag = 1'b0;
                end
                n_byte_index  = 4'd0;
                n_bit_index   = 4'd0;
                n_bit_timer   = {1'b0, bt};
                n_reply_shift = 32'd0;
                n_phase       = swsbm_pkg::PH_TX;
            end
        end else if (i_step) begin
            unique case (r_phase)
                swsbm_pkg::PH_TX: begin
                    n_bit_timer = (r_bit_timer != 17'd0) ? r_bit_timer - 17'd1 : 17'd0;
                    if (n_bit_timer == 17'd0) begin
                        n_bit_index = r_bit_index + 4'd1;
                        n_bit_timer = {1'b0, bt};
                        if (n_bit_index >= swsbm_pkg::UART_BITS) begin
                            n_bit_index  = 4'd0;
                            n_byte_index = r_byte_index + 4'd1;
                            if (n_byte_index >= r_frame_length) begin
                                // End of frame: what follows depends on the command.
                                n_bit_timer = 17'd0;
                                case (r_pending) inside
                                    swsbm_pkg::CMD_MOVE_WAIT: begin
                                        n_phase = swsbm_pkg::PH_LINE_LOW;
                                    end
                                    swsbm_pkg::CMD_POSITION, swsbm_pkg::CMD_QUERY: begin
                                        n_byte_index  = 4'd0;
                                        n_reply_shift = 32'd0;
                                        n_phase       = swsbm_pkg::PH_RX_WAIT;
                                        n_wait_timer  = 24'd0;
                                        n_bit_index   = 4'd0;
                                    end
                                    swsbm_pkg::CMD_ZERO: begin
                                        gap_go  = 1'b1;
                                        gap_len = i_cfg.zero_settle_ticks;
                                    end
                                    default: begin
                                        done    = 1'b1;
                                        n_phase = swsbm_pkg::PH_IDLE;
                                    end
                                endcase
                            end
                        end
                    end
                end
                swsbm_pkg::PH_LINE_LOW: begin
                    if (!i_word.line_level) begin
                        n_phase = swsbm_pkg::PH_LINE_HIGH;
                    end
                end
                swsbm_pkg::PH_LINE_HIGH: begin
                    if (i_word.line_level) begin
                        gap_go  = 1'b1;
                        gap_len = {8'd0, i_cfg.gap_ticks};
                    end
                end
                swsbm_pkg::PH_RX_WAIT: begin
                    if (!i_word.line_level) begin
                        // Start edge: first sample lands in the middle of bit 0.
                        n_phase     = swsbm_pkg::PH_RX_BITS;
                        n_bit_index = 4'd0;
                        n_bit_timer = {1'b0, bt} + {2'b0, half_bt};
                    end else begin
                        n_wait_timer = wait_inc;
                        if (wait_inc >= timeout_lim) begin
                            n_timeout_flag = 1'b1;
                            if (r_pending == swsbm_pkg::CMD_POSITION) begin
                                n_last_position = swsbm_pkg::POS_TIMEOUT;
                            end else begin
                                n_last_moving = 1'b0;
                            end
                            done    = 1'b1;
                            n_phase = swsbm_pkg::PH_IDLE;
                        end
                    end
                end
                swsbm_pkg::PH_RX_BITS: begin
                    n_bit_timer = (r_bit_timer != 17'd0) ? r_bit_timer - 17'd1 : 17'd0;
                    if (n_bit_timer == 17'd0) begin
                        if (r_pending == swsbm_pkg::CMD_QUERY) begin
                            n_last_moving = i_word.line_level;
                            gap_go        = 1'b1;
                            if (i_word.line_level) begin
                                gap_len = (i_cfg.gap_ticks >= {1'b0, half_bt})
                                          ? {8'd0, i_cfg.gap_ticks - {1'b0, half_bt}}
                                          : 24'd0;
                            end else begin
                                gap_len = {7'd0, {1'b0, i_cfg.gap_ticks} + {2'b0, half_bt}};
                            end
                        end else if (r_bit_index < swsbm_pkg::DATA_BITS) begin
                            // Reply bytes arrive most significant first, bits LSB first.
                            if (i_word.line_level && r_byte_index < swsbm_pkg::REPLY_BYTES) begin
                                n_reply_shift[{~r_byte_index[1:0], r_bit_index[2:0]}] = 1'b1;
                            end
                            n_bit_index = r_bit_index + 4'd1;
                            n_bit_timer = {1'b0, bt};
                        end else begin
                            n_byte_index = r_byte_index + 4'd1;
                            if (n_byte_index >= swsbm_pkg::REPLY_BYTES) begin
                                n_last_position = r_reply_shift;
                                gap_go          = 1'b1;
                                gap_len = {7'd0, {1'b0, i_cfg.gap_ticks} + {1'b0, bt}};
                            end else begin
                                n_phase      = swsbm_pkg::PH_RX_WAIT;
                                n_wait_timer = 24'd0;
                                n_bit_index  = 4'd0;
                            end
                        end
                    end
                end
                swsbm_pkg::PH_GAP: begin
                    n_wait_timer = (r_wait_timer != 24'd0) ? r_wait_timer - 24'd1 : 24'd0;
                    if (n_wait_timer == 24'd0) begin
                        done    = 1'b1;
                        n_phase = swsbm_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = swsbm_pkg::PH_IDLE;
                end
            endcase
        end

        // A guard time of zero finishes the command straight away.
        if (gap_go) begin
            if (gap_len == 24'd0) begin
                done    = 1'b1;
                n_phase = swsbm_pkg::PH_IDLE;
            end else begin
                n_phase      = swsbm_pkg::PH_GAP;
                n_wait_timer = gap_len;
            end
        end
    end

    // Wire drive for the state after this word. The frame buffer is only read while
    // sending data bits, which never happens on the word that loads it.
    assign tx_byte    = ({1'b0, n_byte_index} < 5'(FRAME_MAX))
                        ? r_frame[n_byte_index[IDX_W-1:0]] : 8'hFF;
    assign tx_bit_sel = n_bit_index[2:0] - 3'd1;

    always_comb begin
        if (n_phase != swsbm_pkg::PH_TX) begin
            pull = 1'b0;
        end else if (n_bit_index == 4'd0) begin
            pull = 1'b1;
        end else if (n_bit_index > swsbm_pkg::DATA_BITS) begin
            pull = 1'b0;
        end else begin
            pull = ~tx_byte[tx_bit_sel];
        end
    end

    assign o_result.pull_low  = pull;
    assign o_result.busy_res  = (n_phase != swsbm_pkg::PH_IDLE);
    assign o_result.done_res  = done;
    assign o_result.position  = n_last_position;
    assign o_result.moving    = n_last_moving;
    assign o_result.timed_out = n_timeout_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= swsbm_pkg::PH_IDLE;
            r_pending       <= swsbm_pkg::CMD_MOVE;
            r_frame_length  <= 4'd0;
            r_byte_index    <= 4'd0;
            r_bit_index     <= 4'd0;
            r_bit_timer     <= 17'd0;
            r_wait_timer    <= 24'd0;
            r_reply_shift   <= 32'd0;
            r_last_position <= 32'd0;
            r_last_moving   <= 1'b0;
            r_timeout_flag  <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_pending       <= n_pending;
            r_frame_length  <= n_frame_length;
            r_byte_index    <= n_byte_index;
            r_bit_index     <= n_bit_index;
            r_bit_timer     <= n_bit_timer;
            r_wait_timer    <= n_wait_timer;
            r_reply_shift   <= n_reply_shift;
            r_last_position <= n_last_position;
            r_last_moving   <= n_last_moving;
            r_timeout_flag  <= n_timeout_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_en) begin
            r_frame[0] <= swsbm_pkg::SYNC_BYTE;
            r_frame[1] <= {5'd0, cmd_eff};
            r_frame[2] <= i_word.target_angle[31:24];
            r_frame[3] <= i_word.target_angle[23:16];
            r_frame[4] <= i_word.target_angle[15:8];
            r_frame[5] <= i_word.target_angle[7:0];
            r_frame[6] <= i_word.move_speed;
            r_frame[7] <= checksum;
        end
    end

    a_tx_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == swsbm_pkg::PH_TX |-> r_byte_index < r_frame_length
                                        && r_bit_index < swsbm_pkg::UART_BITS)
        else $error("transmit position outside the frame");

    a_rx_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == swsbm_pkg::PH_RX_WAIT || r_phase == swsbm_pkg::PH_RX_BITS)
        |-> (r_pending == swsbm_pkg::CMD_POSITION || r_pending == swsbm_pkg::CMD_QUERY))
        else $error("reply phase entered for a command without a reply");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_word.operation && r_phase == swsbm_pkg::PH_IDLE
        |=> r_phase == swsbm_pkg::PH_IDLE)
        else $error("a tick left the idle phase");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && done |=> r_phase == swsbm_pkg::PH_IDLE)
        else $error("command finished but sequencer is not idle");

endmodule

`default_nettype wire

>>> hdl/single_wire_servo_bus_master_top.sv
// Top level of the single-wire servo bus master: channel registers and configuration.
//
//  Channel   Dir  Payload                                               Handshake
//  i_cmd     in   operation, command, target_angle, move_speed, line    valid/ready
//  o_res     out  pull_low, busy_res, done_res, position, moving, t/o   valid/ready
//  i_cfg_*   in   register index and data                               write enable
//
//  One result word per accepted word, one word per cycle sustained while o_res is not
//  stalled: the whole sequencer step is a single pass between the input and output registers.
//  A word is held in the input register and its result in the output register before o_res.
//  Reset is synchronous and clears the phase, counters and reported status.
//  A stalled o_res holds its word; i_cmd keeps accepting until the input register is full.
`timescale 1ns / 1ps
`default_nettype none

module single_wire_servo_bus_master_top #(
    parameter int FRAME_MAX = swsbm_pkg::FRAME_MAX_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    swsbm_in_if.sink                             i_cmd,
    swsbm_out_if.source                          o_res,
    input  wire                                  i_cfg_we,
    input  wire [swsbm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [swsbm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic                 r_in_valid;
    swsbm_pkg::t_in_word  r_in_word;
    logic                 r_out_valid;
    swsbm_pkg::t_out_word r_out_word;
    swsbm_pkg::t_out_word step_result;
    swsbm_pkg::t_cfg      r_cfg;
    logic                 step;

    // A word moves on when the output register is empty or being emptied.
    assign step        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_word.operation    <= i_cmd.operation;
            r_in_word.command      <= i_cmd.command;
            r_in_word.target_angle <= i_cmd.target_angle;
            r_in_word.move_speed   <= i_cmd.move_speed;
            r_in_word.line_level   <= i_cmd.line_level;
        end
        if (step) begin
            r_out_word <= step_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_ticks           <= swsbm_pkg::BIT_TICKS_RST;
            r_cfg.reply_timeout_ticks <= swsbm_pkg::REPLY_TIMEOUT_RST;
            r_cfg.gap_ticks           <= swsbm_pkg::GAP_TICKS_RST;
            r_cfg.zero_settle_ticks   <= swsbm_pkg::ZERO_SETTLE_RST;
        end else if (i_cfg_we) begin
            unique case (swsbm_pkg::t_cfg_idx'(i_cfg_index))
                swsbm_pkg::CFG_BIT_TICKS:     r_cfg.bit_ticks           <= i_cfg_data[15:0];
                swsbm_pkg::CFG_REPLY_TIMEOUT: r_cfg.reply_timeout_ticks <= i_cfg_data;
                swsbm_pkg::CFG_GAP_TICKS:     r_cfg.gap_ticks           <= i_cfg_data[15:0];
                swsbm_pkg::CFG_ZERO_SETTLE:   r_cfg.zero_settle_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    swsbm_core #(
        .FRAME_MAX (FRAME_MAX)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_in_word),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    assign o_res.valid     = r_out_valid;
    assign o_res.pull_low  = r_out_word.pull_low;
    assign o_res.busy_res  = r_out_word.busy_res;
    assign o_res.done_res  = r_out_word.done_res;
    assign o_res.position  = r_out_word.position;
    assign o_res.moving    = r_out_word.moving;
    assign o_res.timed_out = r_out_word.timed_out;

endmodule

`default_nettype wire
